@@ hdl/ple_pkg.sv @@
// Shared types, codes and constants for the positional list engine.
package ple_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int OP_W    = 2;
    localparam int POS_W   = 6;
    localparam int VAL_W   = 32;
    localparam int ST_W    = 2;
    localparam int CNT_O_W = 7;

    localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OP_W-1:0] OP_TAKE   = 2'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd2;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd3;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic signed [VAL_W-1:0] removed;
        logic [ST_W-1:0]         status;
        logic [CNT_O_W-1:0]      count;
    } t_result;

endpackage

@@ hdl/ple_ram.sv @@
// Entry storage: one write port, one registered read port.
module ple_ram #(
    parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [$clog2(DEPTH)-1:0]     i_waddr,
    input  logic [ple_pkg::VAL_W-1:0]    i_wdata,
    input  logic [$clog2(DEPTH)-1:0]     i_raddr,
    output logic [ple_pkg::VAL_W-1:0]    o_rdata
);

    logic [ple_pkg::VAL_W-1:0] r_mem [DEPTH];
    logic [ple_pkg::VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/ple_ctrl.sv @@
// Sequencer: decodes an operation and walks the entry shift one word a cycle.
module ple_ctrl #(
    parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [ple_pkg::OP_W-1:0]           i_op,
    input  logic [ple_pkg::POS_W-1:0]          i_pos,
    input  logic signed [ple_pkg::VAL_W-1:0]   i_val,
    output logic                               o_res_valid,
    output ple_pkg::t_result                   o_res,
    input  logic                               i_res_take,
    output logic                               o_we,
    output logic [$clog2(DEPTH)-1:0]           o_waddr,
    output logic [ple_pkg::VAL_W-1:0]          o_wdata,
    output logic [$clog2(DEPTH)-1:0]           o_raddr,
    input  logic [ple_pkg::VAL_W-1:0]          i_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    ple_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_pend, n_pend;
    logic            r_open, n_open;
    logic            r_first, n_first;
    logic [AW-1:0]   r_at, n_at;
    logic [AW-1:0]   r_raddr, n_raddr;
    logic [AW-1:0]   r_paddr, n_paddr;
    logic [CW-1:0]   r_rcnt, n_rcnt;
    logic [ple_pkg::VAL_W-1:0] r_val, n_val;
    logic [ple_pkg::VAL_W-1:0] r_removed, n_removed;
    logic [ple_pkg::ST_W-1:0]  r_status, n_status;

    logic [XW-1:0] pos_x;
    logic [XW-1:0] last_x;
    logic [XW-1:0] clamp_x;
    logic          issue;

    assign pos_x   = XW'(i_pos);
    assign last_x  = XW'(r_cnt) - XW'(1);
    assign clamp_x = (pos_x < last_x) ? pos_x : last_x;
    assign issue   = (r_rcnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ple_pkg::S_IDLE;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_open    <= n_open;
        r_first   <= n_first;
        r_at      <= n_at;
        r_raddr   <= n_raddr;
        r_paddr   <= n_paddr;
        r_rcnt    <= n_rcnt;
        r_val     <= n_val;
        r_removed <= n_removed;
        r_status  <= n_status;
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_pend    = r_pend;
        n_open    = r_open;
        n_first   = r_first;
        n_at      = r_at;
        n_raddr   = r_raddr;
        n_paddr   = r_paddr;
        n_rcnt    = r_rcnt;
        n_val     = r_val;
        n_removed = r_removed;
        n_status  = r_status;
        o_ready     = 1'b0;
        o_res_valid = 1'b0;
        o_we        = 1'b0;
        o_waddr     = r_at;
        o_wdata     = r_val;
        o_raddr     = r_raddr;

        case (r_state)
            ple_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_val     = i_val;
                    n_removed = '0;
                    n_status  = ple_pkg::ST_OK;
                    n_pend    = 1'b0;
                    n_first   = 1'b1;
                    if (i_op == ple_pkg::OP_PUSH || i_op == ple_pkg::OP_INSERT) begin
                        if (r_cnt == FULL_CNT) begin
                            n_status = ple_pkg::ST_FULL;
                            n_state  = ple_pkg::S_DONE;
                        end else begin
                            // insert goes just after the clamped position
                            if (i_op == ple_pkg::OP_PUSH || r_cnt == '0) begin
                                n_at = '0;
                            end else begin
                                n_at = AW'(clamp_x + XW'(1));
                            end
                            n_open  = 1'b1;
                            n_rcnt  = r_cnt - CW'(n_at);
                            n_raddr = AW'(r_cnt - CW'(1));
                            n_cnt   = r_cnt + CW'(1);
                            n_state = ple_pkg::S_RUN;
                        end
                    end else begin
                        if (r_cnt == '0) begin
                            n_status = ple_pkg::ST_EMPTY;
                            n_state  = ple_pkg::S_DONE;
                        end else if (i_op == ple_pkg::OP_DELETE && pos_x >= XW'(r_cnt)) begin
                            n_status = ple_pkg::ST_RANGE;
                            n_state  = ple_pkg::S_DONE;
                        end else begin
                            n_at    = (i_op == ple_pkg::OP_TAKE) ? '0 : pos_x[AW-1:0];
                            n_open  = 1'b0;
                            n_rcnt  = r_cnt - CW'(n_at);
                            n_raddr = n_at;
                            n_cnt   = r_cnt - CW'(1);
                            n_state = ple_pkg::S_RUN;
                        end
                    end
                end
            end

            ple_pkg::S_RUN: begin
                // one read per cycle; prior word is written back or kept as removed
                if (issue) begin
                    n_raddr = r_open ? r_raddr - AW'(1) : r_raddr + AW'(1);
                    n_rcnt  = r_rcnt - CW'(1);
                    n_paddr = r_raddr;
                end
                n_pend = issue;
                if (r_pend) begin
                    if (!r_open && r_first) begin
                        n_removed = i_rdata;
                        n_first   = 1'b0;
                    end else begin
                        o_we    = 1'b1;
                        o_waddr = r_open ? r_paddr + AW'(1) : r_paddr - AW'(1);
                        o_wdata = i_rdata;
                    end
                end else if (!issue) begin
                    if (r_open) begin
                        o_we    = 1'b1;
                        o_waddr = r_at;
                        o_wdata = r_val;
                    end
                    n_state = ple_pkg::S_DONE;
                end
            end

            ple_pkg::S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = ple_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = ple_pkg::S_IDLE;
            end
        endcase
    end

    assign o_res.removed = r_removed;
    assign o_res.status  = r_status;
    assign o_res.count   = ple_pkg::CNT_O_W'(r_cnt);

endmodule

@@ hdl/positional_list_engine.sv @@
// Top level of the positional list engine: sequencer, entry memory, output register.
//
// Bounded ordered list of signed 32-bit values. One input transfer carries one
// operation: push front, take front, insert after a position (clamped to the
// last entry), or delete at a position. Every operation yields exactly one
// output transfer with the removed value, a status code and the new count.
//
// Input stream (s_axis): tdata = op[1:0], position[7:2], value[39:8].
// Output stream (m_axis): tdata = removed_value[31:0], status[33:32],
// count[40:34], zero padding [47:41].
// Sequencing: entries sit in a single-port-read memory; the sequencer moves
// one word per cycle between the affected slot and the end of the list, then
// raises its result; a refused operation goes straight to its result.
// o_s_axis_tready is high only while the sequencer is idle, so the next input
// transfer is taken only once the result has moved into the output register.
// The result sits in an output register, so the next input transfer is
// taken while an earlier result waits on a stalled receiver; the sequencer
// holds its next result until that register frees up.
// Reset (synchronous, active low) empties the list; memory is not cleared.
module positional_list_engine #(
    parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // op, position, value (low bit first)
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata    // removed_value, status, count, pad
);

    localparam int AW = $clog2(DEPTH);

    ple_pkg::t_result          res;
    logic                      res_valid;
    logic                      res_take;
    logic                      we;
    logic [AW-1:0]             waddr;
    logic [AW-1:0]             raddr;
    logic [ple_pkg::VAL_W-1:0] wdata;
    logic [ple_pkg::VAL_W-1:0] rdata;

    // output register
    logic             r_m_valid;
    ple_pkg::t_result r_m_res;

    ple_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_op        (i_s_axis_tdata[1:0]),
        .i_pos       (i_s_axis_tdata[7:2]),
        .i_val       (i_s_axis_tdata[39:8]),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    ple_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Load when empty or when the current result leaves this cycle.
    assign res_take = res_valid && (!r_m_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_take) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_m_res <= res;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {7'd0, r_m_res.count, r_m_res.status, r_m_res.removed};

endmodule
